[rtl/bzw_pkg.sv]
// Shared constants, register codes and types for the 2x bilinear window zoom.
package bzw_pkg;

	localparam int MAX_SIDE  = 512;
	localparam int MAX_WIDTH = 4096;

	localparam int PIX_W     = 8;
	localparam int POS_W     = 12;
	localparam int WIDTH_W   = 13;
	localparam int SIDE_REG_W = 10;
	localparam int SIDE_W    = $clog2(MAX_SIDE);
	localparam int COORD_W   = SIDE_W + 1;

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [WIDTH_W-1:0]    IMAGE_WIDTH_RST = WIDTH_W'(640);
	localparam logic [SIDE_REG_W-1:0] SIDE_RST        = SIDE_REG_W'(1);

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_TOP_ROW     = 2'd1,
		REG_LEFT_COL    = 2'd2,
		REG_SIDE        = 2'd3
	} reg_idx_t;

	// output kinds, in emission order; also bit positions of the need mask
	typedef enum logic [1:0] {
		PH_CENTRE = 2'd0,
		PH_VERT   = 2'd1,
		PH_HORZ   = 2'd2,
		PH_COPY   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]    image_width;	// clamped to 1..MAX_WIDTH
		logic [POS_W-1:0]      top_row;
		logic [POS_W-1:0]      left_col;
		logic [SIDE_REG_W-1:0] side;		// clamped to MAX_SIDE
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  p;
		logic [PIX_W-1:0]  l;
		logic [PIX_W-1:0]  al;
		logic [PIX_W-1:0]  a;
		logic [SIDE_W-1:0] wr;
		logic [SIDE_W-1:0] wc;
		logic [3:0]        need;
		logic              last;
	} entry_t;

endpackage

[rtl/bzw_ram.sv]
// Generic single-write, single-read RAM with registered read-first output.
module bzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/bzw_front.sv]
// Front end: raster position, window classification, line buffer access.
module bzw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bzw_pkg::cfg_t               cfg,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [bzw_pkg::PIX_W-1:0]   pixel,
	input  logic                        frame_start,
	input  logic                        full,
	output logic                        push,
	output bzw_pkg::entry_t             push_entry
);

	logic [bzw_pkg::POS_W-1:0]  src_row_q, src_col_q;
	logic [bzw_pkg::POS_W-1:0]  r, c, dr, dc, side_ext, side_m1;
	logic [bzw_pkg::WIDTH_W-1:0] col_inc;
	logic                       accept, in_win, take, wrap;
	logic [bzw_pkg::PIX_W-1:0]  left_q, al_q, a_rd;
	logic                       s1_valid_q;
	logic [bzw_pkg::PIX_W-1:0]  p_s1, l_s1;
	logic [bzw_pkg::SIDE_W-1:0] wr_s1, wc_s1;
	logic [3:0]                 need_s1;
	logic                       last_s1;
	logic [3:0]                 need;

	assign pixel_stall = s1_valid_q & full;
	assign accept      = pixel_valid & ~pixel_stall;
	assign push        = s1_valid_q & ~full;

	assign r       = frame_start ? '0 : src_row_q;
	assign c       = frame_start ? '0 : src_col_q;
	assign col_inc = {1'b0, c} + bzw_pkg::WIDTH_W'(1);
	assign wrap    = col_inc >= cfg.image_width;

	assign dr       = r - cfg.top_row;
	assign dc       = c - cfg.left_col;
	assign side_ext = bzw_pkg::POS_W'(cfg.side);
	assign side_m1  = side_ext - bzw_pkg::POS_W'(1);
	assign in_win   = (r >= cfg.top_row) && (c >= cfg.left_col)
			&& (dr < side_ext) && (dc < side_ext);
	assign take     = accept & in_win;

	always_comb begin
		need                         = '0;
		need[bzw_pkg::PH_CENTRE]     = (dr != '0) && (dc != '0);
		need[bzw_pkg::PH_VERT]       = dr != '0;
		need[bzw_pkg::PH_HORZ]       = dc != '0;
		need[bzw_pkg::PH_COPY]       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_row_q  <= '0;
			src_col_q  <= '0;
			left_q     <= '0;
			al_q       <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				src_col_q <= wrap ? '0 : col_inc[bzw_pkg::POS_W-1:0];
				src_row_q <= wrap ? r + bzw_pkg::POS_W'(1) : r;
			end
			if (take) begin
				left_q <= pixel;
			end
			if (push) begin
				al_q <= a_rd;
			end
			s1_valid_q <= take | (s1_valid_q & full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p_s1    <= pixel;
			l_s1    <= left_q;
			wr_s1   <= dr[bzw_pkg::SIDE_W-1:0];
			wc_s1   <= dc[bzw_pkg::SIDE_W-1:0];
			need_s1 <= need;
			last_s1 <= (dr == side_m1) && (dc == side_m1);
		end
	end

	// read-first: the entry read is the previous window row's value
	bzw_ram #(
		.WIDTH (bzw_pkg::PIX_W),
		.DEPTH (bzw_pkg::MAX_SIDE)
	) u_line_buf (
		.clk   (clk),
		.we    (take),
		.waddr (dc[bzw_pkg::SIDE_W-1:0]),
		.wdata (pixel),
		.re    (take),
		.raddr (dc[bzw_pkg::SIDE_W-1:0]),
		.rdata (a_rd)
	);

	always_comb begin
		push_entry.p    = p_s1;
		push_entry.l    = l_s1;
		push_entry.al   = al_q;
		push_entry.a    = a_rd;
		push_entry.wr   = wr_s1;
		push_entry.wc   = wc_s1;
		push_entry.need = need_s1;
		push_entry.last = last_s1;
	end

endmodule

[rtl/bzw_fifo.sv]
// Short item queue between front and back ends.
module bzw_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bzw_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output bzw_pkg::entry_t head
);

	bzw_pkg::entry_t            slot_q [bzw_pkg::QDEPTH];
	logic [bzw_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [bzw_pkg::QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == bzw_pkg::QCNT_W'(bzw_pkg::QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + bzw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + bzw_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + bzw_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - bzw_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

[rtl/bzw_back.sv]
// Back end: expands one queued item into its zoomed pixels, one per cycle unless stalled.
module bzw_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  bzw_pkg::entry_t               head,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bzw_pkg::PIX_W-1:0]     out_pixel,
	output logic [bzw_pkg::COORD_W-1:0]   out_row,
	output logic [bzw_pkg::COORD_W-1:0]   out_col,
	output logic                          last
);

	logic [3:0]                   done_q, remaining;
	bzw_pkg::phase_t              cur;
	logic                         load;
	logic [bzw_pkg::PIX_W+1:0]    sum4;
	logic [bzw_pkg::PIX_W:0]      sum_v, sum_h;
	logic [bzw_pkg::COORD_W-1:0]  row2, col2, row2_m1, col2_m1;
	logic [bzw_pkg::PIX_W-1:0]    val_d;
	logic [bzw_pkg::COORD_W-1:0]  row_d, col_d;
	logic                         last_d;

	assign remaining = head.need & ~done_q;
	assign load      = head_valid & (~result_valid | ~result_stall);
	assign pop       = load & (cur == bzw_pkg::PH_COPY);

	always_comb begin
		priority if (remaining[bzw_pkg::PH_CENTRE]) begin
			cur = bzw_pkg::PH_CENTRE;
		end else if (remaining[bzw_pkg::PH_VERT]) begin
			cur = bzw_pkg::PH_VERT;
		end else if (remaining[bzw_pkg::PH_HORZ]) begin
			cur = bzw_pkg::PH_HORZ;
		end else begin
			cur = bzw_pkg::PH_COPY;
		end
	end

	assign sum4 = (bzw_pkg::PIX_W+2)'(2) + {2'b00, head.a} + {2'b00, head.al}
			+ {2'b00, head.l} + {2'b00, head.p};
	assign sum_v = {1'b0, head.a} + {1'b0, head.p} + (bzw_pkg::PIX_W+1)'(1);
	assign sum_h = {1'b0, head.l} + {1'b0, head.p} + (bzw_pkg::PIX_W+1)'(1);

	assign row2    = {head.wr, 1'b0};
	assign col2    = {head.wc, 1'b0};
	assign row2_m1 = row2 - bzw_pkg::COORD_W'(1);
	assign col2_m1 = col2 - bzw_pkg::COORD_W'(1);

	always_comb begin
		unique case (cur)
			bzw_pkg::PH_CENTRE: begin
				val_d  = sum4[bzw_pkg::PIX_W+1:2];
				row_d  = row2_m1;
				col_d  = col2_m1;
				last_d = 1'b0;
			end
			bzw_pkg::PH_VERT: begin
				val_d  = sum_v[bzw_pkg::PIX_W:1];
				row_d  = row2_m1;
				col_d  = col2;
				last_d = 1'b0;
			end
			bzw_pkg::PH_HORZ: begin
				val_d  = sum_h[bzw_pkg::PIX_W:1];
				row_d  = row2;
				col_d  = col2_m1;
				last_d = 1'b0;
			end
			default: begin
				val_d  = head.p;
				row_d  = row2;
				col_d  = col2;
				last_d = head.last;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | (4'b0001 << cur);
			end
			if (load) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pixel <= val_d;
			out_row   <= row_d;
			out_col   <= col_d;
			last      <= last_d;
		end
	end

endmodule

[rtl/bilinear_zoom_2x_window.sv]
// Top level: register port, front end, item queue and back end of the 2x window zoom.
// An in-window item's first result goes through the line buffer read, then the queue,
// then the output register.
// Throughput: the output register gives one result per cycle while result_stall is low;
// an in-window item yields one to four results, an item outside the window none.
// Reset (arst_n low, asynchronous): registers return to their defaults, positions and
// neighbour pixels clear, queue and output empty; the line buffer is not cleared.
module bilinear_zoom_2x_window (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bzw_pkg::PADDR_W-1:0]   paddr,
	input  logic [bzw_pkg::PDATA_W-1:0]   pwdata,
	output logic [bzw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// source pixels
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  logic [bzw_pkg::PIX_W-1:0]     pixel,
	input  logic                          frame_start,
	// zoomed pixels
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bzw_pkg::PIX_W-1:0]     out_pixel,
	output logic [bzw_pkg::COORD_W-1:0]   out_row,
	output logic [bzw_pkg::COORD_W-1:0]   out_col,
	output logic                          last
);

	// raw register values, read back as written
	logic [bzw_pkg::WIDTH_W-1:0]    image_width_q;
	logic [bzw_pkg::POS_W-1:0]      top_row_q;
	logic [bzw_pkg::POS_W-1:0]      left_col_q;
	logic [bzw_pkg::SIDE_REG_W-1:0] side_q;

	bzw_pkg::reg_idx_t reg_idx;
	logic              wr_en;
	bzw_pkg::cfg_t     cfg;

	logic              push, full, pop, not_empty;
	bzw_pkg::entry_t   push_entry, head;

	assign pready  = 1'b1;
	assign reg_idx = bzw_pkg::reg_idx_t'(paddr[bzw_pkg::PADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= bzw_pkg::IMAGE_WIDTH_RST;
			top_row_q     <= '0;
			left_col_q    <= '0;
			side_q        <= bzw_pkg::SIDE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				bzw_pkg::REG_IMAGE_WIDTH: image_width_q <= pwdata[bzw_pkg::WIDTH_W-1:0];
				bzw_pkg::REG_TOP_ROW:     top_row_q     <= pwdata[bzw_pkg::POS_W-1:0];
				bzw_pkg::REG_LEFT_COL:    left_col_q    <= pwdata[bzw_pkg::POS_W-1:0];
				bzw_pkg::REG_SIDE:        side_q        <= pwdata[bzw_pkg::SIDE_REG_W-1:0];
				default:                  ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bzw_pkg::REG_IMAGE_WIDTH: prdata = bzw_pkg::PDATA_W'(image_width_q);
			bzw_pkg::REG_TOP_ROW:     prdata = bzw_pkg::PDATA_W'(top_row_q);
			bzw_pkg::REG_LEFT_COL:    prdata = bzw_pkg::PDATA_W'(left_col_q);
			bzw_pkg::REG_SIDE:        prdata = bzw_pkg::PDATA_W'(side_q);
			default:                  prdata = '0;
		endcase
	end

	// effective settings: zero width acts as one, width and side saturate
	always_comb begin
		if (image_width_q == '0) begin
			cfg.image_width = bzw_pkg::WIDTH_W'(1);
		end else if (32'(image_width_q) > bzw_pkg::MAX_WIDTH) begin
			cfg.image_width = bzw_pkg::WIDTH_W'(bzw_pkg::MAX_WIDTH);
		end else begin
			cfg.image_width = image_width_q;
		end
		if (32'(side_q) > bzw_pkg::MAX_SIDE) begin
			cfg.side = bzw_pkg::SIDE_REG_W'(bzw_pkg::MAX_SIDE);
		end else begin
			cfg.side = side_q;
		end
		cfg.top_row  = top_row_q;
		cfg.left_col = left_col_q;
	end

	// front: tracks raster position, drops pixels outside the window,
	// reads and rewrites the line buffer and gathers the neighbours
	bzw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.frame_start (frame_start),
		.full        (full),
		.push        (push),
		.push_entry  (push_entry)
	);

	// four items of slack so the front keeps taking pixels while the back
	// expands each into up to four results
	bzw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// back: centre, vert, horiz, copy as needed, in order, one per cycle unless stalled
	bzw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (not_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_pixel    (out_pixel),
		.out_row      (out_row),
		.out_col      (out_col),
		.last         (last)
	);

endmodule

[rtl/bzw_checker.sv]
// Port-level checks for the 2x window zoom, bound to the top level.
module bzw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pixel_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [bzw_pkg::PIX_W-1:0]   out_pixel,
	input logic [bzw_pkg::COORD_W-1:0] out_row,
	input logic [bzw_pkg::COORD_W-1:0] out_col,
	input logic                        last
);

	// output register still empty at the first edge after reset
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !result_valid)
		else $error("result_valid high straight after reset");

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_pixel)
		&& $stable(out_row) && $stable(out_col) && $stable(last))
		else $error("stalled result changed");

	// the final pixel sits on the diagonal at even coordinates
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> out_row == out_col && !out_row[0])
		else $error("last on wrong position");

	// input back-pressure only when the queue is full, so results must be pending
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid)
		else $error("input stalled with no result pending");

endmodule

bind bilinear_zoom_2x_window bzw_checker u_bzw_checker (.*);
